@@ rtl/dkps_pkg.sv @@
// ----------------------------------------------------------------------------
// dkps_pkg
// shared types and constants of the keyframe pair sampler
// ----------------------------------------------------------------------------
package dkps_pkg;

    // table depth default
    localparam int TABLE_DEPTH_DEF = 1024;

    // field widths
    localparam int POS_W   = 25;
    localparam int FRAC_W  = 12;
    localparam int FRAME_W = POS_W - FRAC_W;
    localparam int ENTRY_W = 10;
    localparam int VAL_W   = 32;
    localparam int KEY_W   = 2 * VAL_W;
    localparam int NARROW_W = 16;

    // key index width: frame number plus one carry bit
    localparam int IDX_W = FRAME_W + 1;

    // exact sum width for three times near plus far
    localparam int SUM_W = VAL_W + 3;

    // configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int STEP_W = 2;

    // register indexes
    localparam logic [1:0] REG_STEP_MODE   = 2'd0;
    localparam logic [1:0] REG_LAST_INTERP = 2'd1;
    localparam logic [1:0] REG_NARROW      = 2'd2;

    // step mode codes
    localparam logic [STEP_W-1:0] STEP_EVERY = 2'd0;

    // operation codes
    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    // interpolation kind of a sample
    typedef enum logic [1:0] {
        KIND_DIRECT  = 2'd0,
        KIND_MID     = 2'd1,
        KIND_QUARTER = 2'd2
    } t_kind;

endpackage

@@ rtl/decimated_keyframe_pair_sampler.sv @@
// ----------------------------------------------------------------------------
// decimated_keyframe_pair_sampler
// path: a taken beat passes the stage 1, 2, 3 and output registers to o_valid
// throughput: one load or sample beat per cycle unless busy, dual-read key ram
// stages: index decode and ram access, widen and add, shift and output
// reset: synchronous active low, clears config, valid bits and holds busy;
// the key table keeps its contents and the receiver cannot stall results
// ----------------------------------------------------------------------------
module decimated_keyframe_pair_sampler #(
    parameter int TABLE_DEPTH = dkps_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command channel
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_operation,
    input  logic [dkps_pkg::POS_W-1:0]       i_frame_position,
    input  logic [dkps_pkg::ENTRY_W-1:0]     i_entry_index,
    input  logic signed [dkps_pkg::VAL_W-1:0] i_load_first,
    input  logic signed [dkps_pkg::VAL_W-1:0] i_load_second,
    // result channel
    output logic                             o_valid,
    output logic signed [dkps_pkg::VAL_W-1:0] o_first_value,
    output logic signed [dkps_pkg::VAL_W-1:0] o_second_value,
    output logic                             o_index_fault,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dkps_pkg::ADDR_W-1:0]      paddr,
    input  logic [dkps_pkg::DATA_W-1:0]      pwdata,
    output logic [dkps_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int IDX_W = dkps_pkg::IDX_W;
    localparam int VAL_W = dkps_pkg::VAL_W;
    localparam int SUM_W = dkps_pkg::SUM_W;
    localparam int FW    = dkps_pkg::FRAME_W;
    localparam logic [IDX_W-1:0] DEPTH = IDX_W'(TABLE_DEPTH);

    // value of one stored half, narrow or full width
    function automatic logic signed [VAL_W-1:0] f_widen(
        input logic [VAL_W-1:0] bits,
        input logic             narrow
    );
        logic signed [VAL_W-1:0] res;
        if (narrow) begin
            res = {{(VAL_W-dkps_pkg::NARROW_W){bits[dkps_pkg::NARROW_W-1]}},
                   bits[dkps_pkg::NARROW_W-1:0]};
        end else begin
            res = bits;
        end
        return res;
    endfunction

    // configuration registers
    logic [dkps_pkg::STEP_W-1:0] r_step_mode;
    logic [FW-1:0]               r_last_interp;
    logic                        r_narrow;
    logic                        r_busy;
    logic                        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign busy      = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_mode   <= dkps_pkg::STEP_EVERY;
            r_last_interp <= '0;
            r_narrow      <= 1'b0;
            r_busy        <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (cfg_write) begin
                unique case (paddr[3:2])
                    dkps_pkg::REG_STEP_MODE:   r_step_mode   <= pwdata[dkps_pkg::STEP_W-1:0];
                    dkps_pkg::REG_LAST_INTERP: r_last_interp <= pwdata[FW-1:0];
                    dkps_pkg::REG_NARROW:      r_narrow      <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            dkps_pkg::REG_STEP_MODE:   prdata = dkps_pkg::DATA_W'(r_step_mode);
            dkps_pkg::REG_LAST_INTERP: prdata = dkps_pkg::DATA_W'(r_last_interp);
            dkps_pkg::REG_NARROW:      prdata = dkps_pkg::DATA_W'(r_narrow);
            default:                   prdata = '0;
        endcase
    end

    // stage 1: capture the beat
    logic                r_s1_valid;
    dkps_pkg::t_op       r_s1_op;
    logic [FW-1:0]       r_s1_frame;
    logic [dkps_pkg::ENTRY_W-1:0] r_s1_entry;
    logic [dkps_pkg::KEY_W-1:0]   r_s1_key;
    logic                accept;

    assign accept = start & ~r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op    <= dkps_pkg::t_op'(i_operation);
            r_s1_frame <= i_frame_position[dkps_pkg::POS_W-1:dkps_pkg::FRAC_W];
            r_s1_entry <= i_entry_index;
            r_s1_key   <= {i_load_second, i_load_first};
        end
    end

    // stage 1 logic: key indexes and interpolation kind
    logic [IDX_W-1:0]    idx_a;
    logic [IDX_W-1:0]    idx_b;
    logic [IDX_W-1:0]    frame_x;
    logic [IDX_W-1:0]    last_x;
    logic [IDX_W-1:0]    load_idx;
    dkps_pkg::t_kind     kind;
    logic                sample_fault;
    logic                load_fault;
    logic                s1_fault;
    logic                mem_we;

    assign frame_x  = IDX_W'(r_s1_frame);
    assign last_x   = IDX_W'(r_last_interp);
    assign load_idx = IDX_W'(r_s1_entry);

    always_comb begin
        idx_a = frame_x;
        idx_b = frame_x;
        kind  = dkps_pkg::KIND_DIRECT;
        priority if (r_step_mode == dkps_pkg::STEP_EVERY) begin
            idx_a = frame_x;
        end else if (r_step_mode[0]) begin
            // key every second frame
            if (frame_x[0]) begin
                if (frame_x > last_x) begin
                    idx_a = (last_x >> 1) + IDX_W'(1);
                end else begin
                    idx_a = frame_x >> 1;
                    idx_b = (frame_x >> 1) + IDX_W'(1);
                    kind  = dkps_pkg::KIND_MID;
                end
            end else begin
                idx_a = frame_x >> 1;
            end
        end else begin
            // key every fourth frame
            if (frame_x[1:0] != 2'b00) begin
                if (frame_x > last_x) begin
                    idx_a = (last_x >> 2) + IDX_W'(frame_x[1:0]);
                end else if (frame_x[0]) begin
                    if (frame_x[1]) begin
                        idx_b = frame_x >> 2;
                        idx_a = (frame_x >> 2) + IDX_W'(1);
                    end else begin
                        idx_a = frame_x >> 2;
                        idx_b = (frame_x >> 2) + IDX_W'(1);
                    end
                    kind = dkps_pkg::KIND_QUARTER;
                end else begin
                    idx_a = frame_x >> 2;
                    idx_b = (frame_x >> 2) + IDX_W'(1);
                    kind  = dkps_pkg::KIND_MID;
                end
            end else begin
                idx_a = frame_x >> 2;
            end
        end
    end

    assign sample_fault = (idx_a >= DEPTH) ||
                          ((kind != dkps_pkg::KIND_DIRECT) && (idx_b >= DEPTH));
    assign load_fault   = load_idx >= DEPTH;
    assign s1_fault     = (r_s1_op == dkps_pkg::OP_LOAD) ? load_fault : sample_fault;
    assign mem_we       = r_s1_valid && (r_s1_op == dkps_pkg::OP_LOAD) && !load_fault;

    // key table: one write port, two registered read ports
    logic [dkps_pkg::KEY_W-1:0] r_key_mem [TABLE_DEPTH];
    logic [dkps_pkg::KEY_W-1:0] r_rd_a;
    logic [dkps_pkg::KEY_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_key_mem[load_idx[AW-1:0]] <= r_s1_key;
        end
        r_rd_a <= r_key_mem[idx_a[AW-1:0]];
        r_rd_b <= r_key_mem[idx_b[AW-1:0]];
    end

    // stage 2: control travelling with the read data
    logic            r_s2_valid;
    dkps_pkg::t_kind r_s2_kind;
    logic            r_s2_zero;
    logic            r_s2_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_kind  <= kind;
        r_s2_zero  <= (r_s1_op == dkps_pkg::OP_LOAD) || s1_fault;
        r_s2_fault <= s1_fault;
    end

    // stage 2 logic: widen halves and form exact sums
    logic signed [SUM_W-1:0] a_first;
    logic signed [SUM_W-1:0] a_second;
    logic signed [SUM_W-1:0] b_first;
    logic signed [SUM_W-1:0] b_second;
    logic signed [SUM_W-1:0] n_sum_first;
    logic signed [SUM_W-1:0] n_sum_second;

    assign a_first  = SUM_W'(f_widen(r_rd_a[VAL_W-1:0], r_narrow));
    assign a_second = SUM_W'(f_widen(r_rd_a[2*VAL_W-1:VAL_W], r_narrow));
    assign b_first  = SUM_W'(f_widen(r_rd_b[VAL_W-1:0], r_narrow));
    assign b_second = SUM_W'(f_widen(r_rd_b[2*VAL_W-1:VAL_W], r_narrow));

    always_comb begin
        unique case (r_s2_kind)
            dkps_pkg::KIND_DIRECT: begin
                n_sum_first  = a_first;
                n_sum_second = a_second;
            end
            dkps_pkg::KIND_MID: begin
                n_sum_first  = a_first + b_first;
                n_sum_second = a_second + b_second;
            end
            dkps_pkg::KIND_QUARTER: begin
                n_sum_first  = (a_first <<< 1) + a_first + b_first;
                n_sum_second = (a_second <<< 1) + a_second + b_second;
            end
            default: begin
                n_sum_first  = '0;
                n_sum_second = '0;
            end
        endcase
    end

    // stage 3: registered sums
    logic                    r_s3_valid;
    dkps_pkg::t_kind         r_s3_kind;
    logic                    r_s3_zero;
    logic                    r_s3_fault;
    logic signed [SUM_W-1:0] r_s3_sum_first;
    logic signed [SUM_W-1:0] r_s3_sum_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_kind       <= r_s2_kind;
        r_s3_zero       <= r_s2_zero;
        r_s3_fault      <= r_s2_fault;
        r_s3_sum_first  <= n_sum_first;
        r_s3_sum_second <= n_sum_second;
    end

    // stage 3 logic: floor shift by the interpolation weight
    logic signed [VAL_W-1:0] n_first;
    logic signed [VAL_W-1:0] n_second;

    always_comb begin
        unique case (r_s3_kind)
            dkps_pkg::KIND_DIRECT: begin
                n_first  = r_s3_sum_first[VAL_W-1:0];
                n_second = r_s3_sum_second[VAL_W-1:0];
            end
            dkps_pkg::KIND_MID: begin
                n_first  = r_s3_sum_first[VAL_W:1];
                n_second = r_s3_sum_second[VAL_W:1];
            end
            dkps_pkg::KIND_QUARTER: begin
                n_first  = r_s3_sum_first[VAL_W+1:2];
                n_second = r_s3_sum_second[VAL_W+1:2];
            end
            default: begin
                n_first  = '0;
                n_second = '0;
            end
        endcase
        if (r_s3_zero) begin
            n_first  = '0;
            n_second = '0;
        end
    end

    // output register, one beat per strobe
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_first;
    logic signed [VAL_W-1:0] r_out_second;
    logic                    r_out_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_first  <= n_first;
        r_out_second <= n_second;
        r_out_fault  <= r_s3_fault;
    end

    assign o_valid        = r_out_valid;
    assign o_first_value  = r_out_first;
    assign o_second_value = r_out_second;
    assign o_index_fault  = r_out_fault;

endmodule

@@ rtl/dkps_checker.sv @@
// ----------------------------------------------------------------------------
// dkps_checker
// port-level checks of the keyframe pair sampler, bound to the top level
// ----------------------------------------------------------------------------
module dkps_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              i_operation,
    input  logic                              o_valid,
    input  logic signed [dkps_pkg::VAL_W-1:0] o_first_value,
    input  logic signed [dkps_pkg::VAL_W-1:0] o_second_value,
    input  logic                              o_index_fault
);

    logic beat_in;

    assign beat_in = start && !busy;

    // every taken beat gives a result
    a_beat_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        beat_in |-> ##4 o_valid
    ) else $error("taken beat without result");

    // no result without a matching taken beat
    a_no_invented_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(beat_in, 4)
    ) else $error("result without a taken beat");

    // a faulted result carries zeros
    a_fault_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_index_fault) |-> (o_first_value == '0 && o_second_value == '0)
    ) else $error("faulted result not zero");

    // a load beat returns zeros
    a_load_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(beat_in && (i_operation == dkps_pkg::OP_LOAD), 4))
            |-> (o_first_value == '0 && o_second_value == '0)
    ) else $error("load result not zero");

    // busy holds off beats through reset
    a_busy_in_reset: assert property (
        @(posedge i_clk)
        !i_rst_n |=> busy
    ) else $error("not busy after reset edge");

endmodule

bind decimated_keyframe_pair_sampler dkps_checker u_dkps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_operation    (i_operation),
    .o_valid        (o_valid),
    .o_first_value  (o_first_value),
    .o_second_value (o_second_value),
    .o_index_fault  (o_index_fault)
);
